>>> src/rstab_pkg.sv
// ----------------------------------------------------------------------------
// rstab_pkg: shared types and constants for the ramp slot table
// Slot count, request codes and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package rstab_pkg;

  // table geometry
  localparam int SLOTS  = 512;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PROG_W = 17;
  localparam logic [PROG_W-1:0] FULL_SCALE = 17'h10000;

  // request codes
  localparam logic [2:0] REQ_CREATE   = 3'd0;
  localparam logic [2:0] REQ_TICK     = 3'd1;
  localparam logic [2:0] REQ_FORWARD  = 3'd2;
  localparam logic [2:0] REQ_BACKWARD = 3'd3;
  localparam logic [2:0] REQ_RELEASE  = 3'd4;
  localparam logic [2:0] REQ_QUERY    = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;   // capture the input beat
    logic clr_wr;     // clearing pass: write valid = 0 at counter
    logic cnt_inc;    // counter + 1
    logic cr_start;   // advance next-fit, load counter with it
    logic cr_next;    // next create candidate
    logic cr_take;    // allocate slot at counter
    logic cr_fail;    // table full
    logic tk_start;   // counter to slot 1
    logic div_start;  // start step division for slot at counter
    logic prog_wr;    // write updated progress at counter
    logic flag_wr;    // write direction at slot_id
    logic rel_wr;     // clear valid at slot_id
    logic out_load;   // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] req;
    logic       usable;     // slot_id in 1..SLOTS-1
    logic       cnt_last;   // counter at last slot
    logic       tries_last; // last create candidate
    logic       slot_free;  // read slot not valid
    logic       slot_live;  // read slot valid with nonzero duration
    logic       div_done;
    logic       out_free;   // output register can take a beat
  } stat_t;

  // next slot in cyclic order, skipping slot 0
  function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS - 1)) ? SLOT_W'(1) : s + SLOT_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> src/rstab_ram.sv
// ----------------------------------------------------------------------------
// rstab_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rstab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/rstab_div.sv
// ----------------------------------------------------------------------------
// rstab_div: ramp step divider
// Computes min(elapsed*65536/duration, 65536), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rstab_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [31:0]                   elapsed,
  input  wire logic [31:0]                   duration,
  output logic                               done,
  output logic [rstab_pkg::PROG_W-1:0]       step
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sat_r, sat_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [16:0] bits_r, bits_nxt;
  logic [16:0] q_r, q_nxt;
  logic [32:0] trial;
  logic        ge;

  // one restoring step
  assign trial = {rem_r, bits_r[16]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bits_nxt = bits_r;
    q_nxt    = q_r;
    if (start) begin
      // quotient >= 2^17 whenever elapsed/2 >= duration
      busy_nxt = 1'b1;
      sat_nxt  = ({1'b0, elapsed[31:1]} >= duration);
      cnt_nxt  = 5'd17;
      rem_nxt  = {1'b0, elapsed[31:1]};
      den_nxt  = duration;
      bits_nxt = {elapsed[0], 16'h0};
      q_nxt    = '0;
    end else if (busy_r) begin
      if (sat_r) begin
        q_nxt    = rstab_pkg::FULL_SCALE;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        q_nxt    = {q_r[15:0], ge};
        bits_nxt = {bits_r[15:0], 1'b0};
        cnt_nxt  = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sat_r  <= sat_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    bits_r <= bits_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign step = (q_r > rstab_pkg::FULL_SCALE) ? rstab_pkg::FULL_SCALE : q_r;

endmodule
`default_nettype wire

>>> src/rstab_dp.sv
// ----------------------------------------------------------------------------
// rstab_dp: ramp slot table datapath
// Request latch, slot counter, slot memories, step divider and result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module rstab_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rstab_pkg::cmd_t    cmd,
  output rstab_pkg::stat_t        stat,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [8:0]         in_slot_id,
  input  wire logic [31:0]        in_duration_us,
  input  wire logic signed [31:0] in_start_value,
  input  wire logic signed [31:0] in_end_value,
  input  wire logic [31:0]        in_elapsed_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [8:0]              out_result_slot,
  output logic                    out_status,
  output logic [16:0]             out_progress,
  output logic                    out_reached_end,
  output logic                    out_finished,
  output logic signed [31:0]      out_start,
  output logic signed [31:0]      out_end
);

  localparam int SW = rstab_pkg::SLOT_W;
  localparam int PW = rstab_pkg::PROG_W;

  // request latch
  logic [2:0]  req_r;
  logic [8:0]  sid_r;
  logic [31:0] dur_r, sv_r, ev_r, el_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_req_type;
      sid_r <= in_slot_id;
      dur_r <= in_duration_us;
      sv_r  <= in_start_value;
      ev_r  <= in_end_value;
      el_r  <= in_elapsed_us;
    end
  end

  logic [SW-1:0] sid_a;
  logic          usable;
  assign sid_a  = SW'(sid_r);
  assign usable = (sid_r != 9'd0) && (32'(sid_r) < 32'(rstab_pkg::SLOTS));

  // slot counter, create candidate count, next-fit pointer
  logic [SW-1:0] cnt_r, cnt_nxt, tries_r, tries_nxt, nf_r, nf_nxt, nf_adv;
  logic          status_r, status_nxt;
  logic [8:0]    rslot_r, rslot_nxt;

  assign nf_adv = rstab_pkg::wrap_next(nf_r);

  always_comb begin
    cnt_nxt    = cnt_r;
    tries_nxt  = tries_r;
    nf_nxt     = nf_r;
    status_nxt = status_r;
    rslot_nxt  = rslot_r;
    if (cmd.cnt_inc)  cnt_nxt = cnt_r + SW'(1);
    if (cmd.tk_start) cnt_nxt = SW'(1);
    if (cmd.cr_start) begin
      cnt_nxt   = nf_adv;
      nf_nxt    = nf_adv;
      tries_nxt = '0;
    end
    if (cmd.cr_next) begin
      cnt_nxt   = rstab_pkg::wrap_next(cnt_r);
      tries_nxt = tries_r + SW'(1);
    end
    if (cmd.cr_take) begin
      nf_nxt     = cnt_r;
      status_nxt = 1'b0;
      rslot_nxt  = 9'(cnt_r);
    end
    if (cmd.cr_fail) begin
      status_nxt = 1'b1;
      rslot_nxt  = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      nf_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      nf_r  <= nf_nxt;
    end
    tries_r  <= tries_nxt;
    status_r <= status_nxt;
    rslot_r  <= rslot_nxt;
  end

  // slot memories
  logic [SW-1:0] raddr;
  logic          v_q, b_q;
  logic [31:0]   d_q;
  logic [63:0]   se_q;
  logic [PW-1:0] p_q, p_new, step;
  logic [PW:0]   p_sum;
  logic          div_done;

  assign raddr = (req_r == rstab_pkg::REQ_QUERY) ? sid_a : cnt_r;

  rstab_ram #(.WIDTH(1), .DEPTH(rstab_pkg::SLOTS)) u_valid (
    .clk(clk), .we(cmd.clr_wr | cmd.cr_take | cmd.rel_wr),
    .waddr(cmd.rel_wr ? sid_a : cnt_r), .wdata(cmd.cr_take),
    .raddr(raddr), .rdata(v_q)
  );

  rstab_ram #(.WIDTH(32), .DEPTH(rstab_pkg::SLOTS)) u_dur (
    .clk(clk), .we(cmd.cr_take), .waddr(cnt_r), .wdata(dur_r),
    .raddr(raddr), .rdata(d_q)
  );

  rstab_ram #(.WIDTH(64), .DEPTH(rstab_pkg::SLOTS)) u_se (
    .clk(clk), .we(cmd.cr_take), .waddr(cnt_r), .wdata({sv_r, ev_r}),
    .raddr(raddr), .rdata(se_q)
  );

  rstab_ram #(.WIDTH(PW), .DEPTH(rstab_pkg::SLOTS)) u_prog (
    .clk(clk), .we(cmd.cr_take | cmd.prog_wr), .waddr(cnt_r),
    .wdata(cmd.cr_take ? '0 : p_new),
    .raddr(raddr), .rdata(p_q)
  );

  rstab_ram #(.WIDTH(1), .DEPTH(rstab_pkg::SLOTS)) u_bwd (
    .clk(clk), .we(cmd.cr_take | cmd.flag_wr),
    .waddr(cmd.flag_wr ? sid_a : cnt_r),
    .wdata(cmd.flag_wr & (req_r == rstab_pkg::REQ_BACKWARD)),
    .raddr(raddr), .rdata(b_q)
  );

  // step division
  rstab_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .elapsed(el_r), .duration(d_q), .done(div_done), .step(step)
  );

  // progress update with clamp to 0..full scale
  assign p_sum = {1'b0, p_q} + {1'b0, step};
  always_comb begin
    if (b_q) begin
      p_new = (p_q > step) ? p_q - step : '0;
    end else begin
      p_new = (p_sum > {1'b0, rstab_pkg::FULL_SCALE}) ? rstab_pkg::FULL_SCALE
                                                      : p_sum[PW-1:0];
    end
  end

  // result beat
  logic       q_ok, is_flag;
  logic       out_valid_r;
  logic [8:0] rs_nxt;

  assign q_ok    = (req_r == rstab_pkg::REQ_QUERY) && usable;
  assign is_flag = (req_r == rstab_pkg::REQ_FORWARD) || (req_r == rstab_pkg::REQ_BACKWARD)
                || (req_r == rstab_pkg::REQ_RELEASE) || (req_r == rstab_pkg::REQ_QUERY);

  always_comb begin
    case (req_r)
      rstab_pkg::REQ_CREATE: rs_nxt = rslot_r;
      default:               rs_nxt = is_flag ? sid_r : 9'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_result_slot <= rs_nxt;
      out_status      <= (req_r == rstab_pkg::REQ_CREATE) & status_r;
      out_progress    <= q_ok ? p_q : '0;
      out_reached_end <= q_ok & (p_q == rstab_pkg::FULL_SCALE);
      out_finished    <= q_ok & b_q & (p_q == '0);
      out_start       <= q_ok ? se_q[63:32] : '0;
      out_end         <= q_ok ? se_q[31:0] : '0;
    end
  end

  assign out_valid = out_valid_r;

  // status to controller
  assign stat.req        = req_r;
  assign stat.usable     = usable;
  assign stat.cnt_last   = (cnt_r == SW'(rstab_pkg::SLOTS - 1));
  assign stat.tries_last = (tries_r == SW'(rstab_pkg::SLOTS - 2));
  assign stat.slot_free  = !v_q;
  assign stat.slot_live  = v_q && (d_q != 32'd0);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

>>> src/rstab_ctrl.sv
// ----------------------------------------------------------------------------
// rstab_ctrl: ramp slot table controller
// Sequences the clearing pass, create search, tick walk and single-slot ops.
// ----------------------------------------------------------------------------
`default_nettype none
module rstab_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rstab_pkg::stat_t stat,
  output rstab_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_CR_RD  = 4'd3;
  localparam logic [3:0] S_CR_CHK = 4'd4;
  localparam logic [3:0] S_TK_RD  = 4'd5;
  localparam logic [3:0] S_TK_CHK = 4'd6;
  localparam logic [3:0] S_TK_DIV = 4'd7;
  localparam logic [3:0] S_QWAIT  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      // clear valid bits after reset
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.req)
          rstab_pkg::REQ_CREATE: begin
            cmd.cr_start = 1'b1;
            state_nxt    = S_CR_RD;
          end
          rstab_pkg::REQ_TICK: begin
            cmd.tk_start = 1'b1;
            state_nxt    = S_TK_RD;
          end
          rstab_pkg::REQ_FORWARD, rstab_pkg::REQ_BACKWARD: begin
            cmd.flag_wr = stat.usable;
            state_nxt   = S_OUT;
          end
          rstab_pkg::REQ_RELEASE: begin
            cmd.rel_wr = stat.usable;
            state_nxt  = S_OUT;
          end
          rstab_pkg::REQ_QUERY: state_nxt = S_QWAIT;
          default:              state_nxt = S_OUT;
        endcase
      end
      // next-fit search, a read state and a check state per candidate
      S_CR_RD: state_nxt = S_CR_CHK;
      S_CR_CHK: begin
        if (stat.slot_free) begin
          cmd.cr_take = 1'b1;
          state_nxt   = S_OUT;
        end else if (stat.tries_last) begin
          cmd.cr_fail = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.cr_next = 1'b1;
          state_nxt   = S_CR_RD;
        end
      end
      // tick walk over slots 1..SLOTS-1
      S_TK_RD: state_nxt = S_TK_CHK;
      S_TK_CHK: begin
        if (stat.slot_live) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_TK_DIV;
        end else if (stat.cnt_last) begin
          state_nxt = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_TK_RD;
        end
      end
      S_TK_DIV: begin
        if (stat.div_done) begin
          cmd.prog_wr = 1'b1;
          if (stat.cnt_last) begin
            state_nxt = S_OUT;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_TK_RD;
          end
        end
      end
      S_QWAIT: state_nxt = S_OUT;
      // hand the result beat to the output register
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/ramp_slot_table_top.sv
// ----------------------------------------------------------------------------
// ramp_slot_table_top: table of ramp channels with next-fit allocation
// Controller plus datapath; slot state lives in block RAMs.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | req_type, slot_id, duration_us,
//           |           |                    | start_value, end_value, elapsed_us
//   out_    | output    | out_valid/out_stall| result_slot, status, progress,
//           |           |                    | reached_end, finished, start, end
//
// Create probes slots in next-fit order, up to SLOTS-1 of them.
// Tick walks slots 1..SLOTS-1 and runs the bit-serial step divider for each
// live slot, which sets the tick length.
// After reset a clearing pass over all SLOTS slots runs before the first beat.
// A waiting result beat does not block the next input beat's acceptance.
// ----------------------------------------------------------------------------
`default_nettype none
module ramp_slot_table_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [8:0]         in_slot_id,
  input  wire logic [31:0]        in_duration_us,
  input  wire logic signed [31:0] in_start_value,
  input  wire logic signed [31:0] in_end_value,
  input  wire logic [31:0]        in_elapsed_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [8:0]              out_result_slot,
  output logic                    out_status,
  output logic [16:0]             out_progress,
  output logic                    out_reached_end,
  output logic                    out_finished,
  output logic signed [31:0]      out_start,
  output logic signed [31:0]      out_end
);

  rstab_pkg::cmd_t  cmd;
  rstab_pkg::stat_t stat;

  rstab_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  rstab_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_req_type(in_req_type), .in_slot_id(in_slot_id),
    .in_duration_us(in_duration_us), .in_start_value(in_start_value),
    .in_end_value(in_end_value), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_slot(out_result_slot), .out_status(out_status),
    .out_progress(out_progress), .out_reached_end(out_reached_end),
    .out_finished(out_finished), .out_start(out_start), .out_end(out_end)
  );

endmodule
`default_nettype wire

>>> tb/ramp_slot_table_top_test.sv
// ----------------------------------------------------------------------------
// ramp_slot_table_top_test: self-checking bench for the ramp slot table
// Builds request beats with a built-in slot table predictor, feeds them through
// a queue-driven driver with random gaps, and checks every result beat
// against the predicted one with random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ramp_slot_table_top_test;

  localparam int SLOTS = rstab_pkg::SLOTS;
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]         req;
    logic [8:0]         sid;
    logic [31:0]        dur;
    logic signed [31:0] sv;
    logic signed [31:0] ev;
    logic [31:0]        el;
  } ramp_req_t;

  typedef struct {
    logic [8:0]         slot;
    logic               status;
    logic [16:0]        prog;
    logic               reached;
    logic               fin;
    logic signed [31:0] os;
    logic signed [31:0] oe;
  } ramp_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [8:0] in_slot_id = '0;
  logic [31:0] in_duration_us = '0;
  logic signed [31:0] in_start_value = '0;
  logic signed [31:0] in_end_value = '0;
  logic [31:0] in_elapsed_us = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [8:0] out_result_slot;
  logic out_status;
  logic [16:0] out_progress;
  logic out_reached_end;
  logic out_finished;
  logic signed [31:0] out_start;
  logic signed [31:0] out_end;

  ramp_slot_table_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the table
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_dur   [SLOTS];
  logic [31:0] tbl_start [SLOTS];
  logic [31:0] tbl_end   [SLOTS];
  logic [16:0] tbl_prog  [SLOTS];
  logic        tbl_back  [SLOTS];
  logic        tbl_made  [SLOTS];
  int          tbl_next;
  int          live_cnt;

  ramp_req_t   pending_reqs[$];
  ramp_rsp_t   pending_rsps[$];
  ramp_rsp_t   awaited_rsps[$];
  int          errs = 0;
  int          cyc = 0;
  logic        took = 1'b0;
  logic        gen_done = 1'b0;

  function automatic int wrap_slot(input int s);
    s = s % SLOTS;
    return (s == 0) ? 1 : s;
  endfunction

  // advance the predicted table by one request and queue the beat
  function automatic void issue(input ramp_req_t r);
    ramp_rsp_t o;
    int pick;
    int cand;
    logic [63:0] step;
    logic [31:0] p;
    bit usable;
    o = '{default: '0};
    pick = 0;
    usable = (r.sid != 0) && (int'(r.sid) < SLOTS);
    case (r.req)
      rstab_pkg::REQ_CREATE: begin
        tbl_next = wrap_slot(tbl_next + 1);
        for (int i = 0; i < SLOTS; i++) begin
          cand = wrap_slot(tbl_next + i);
          if (!tbl_valid[cand]) begin
            pick = cand;
            break;
          end
        end
        if (pick == 0) begin
          o.status = 1'b1;
        end else begin
          tbl_next = pick;
          tbl_valid[pick] = 1'b1;
          tbl_made[pick] = 1'b1;
          tbl_dur[pick] = r.dur;
          tbl_start[pick] = r.sv;
          tbl_end[pick] = r.ev;
          tbl_prog[pick] = '0;
          tbl_back[pick] = 1'b0;
          o.slot = pick[8:0];
          live_cnt++;
        end
      end
      rstab_pkg::REQ_TICK: begin
        for (int i = 1; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_dur[i] != 0) begin
            step = {16'd0, r.el, 16'd0} / {32'd0, tbl_dur[i]};
            if (step > 64'd65536) step = 64'd65536;
            p = {15'd0, tbl_prog[i]};
            if (!tbl_back[i]) begin
              p = p + step[31:0];
              if (p > 32'd65536) p = 32'd65536;
            end else begin
              p = (p > step[31:0]) ? p - step[31:0] : 32'd0;
            end
            tbl_prog[i] = p[16:0];
          end
        end
      end
      rstab_pkg::REQ_FORWARD, rstab_pkg::REQ_BACKWARD: begin
        o.slot = r.sid;
        if (usable) tbl_back[r.sid] = (r.req == rstab_pkg::REQ_BACKWARD);
      end
      rstab_pkg::REQ_RELEASE: begin
        o.slot = r.sid;
        if (usable && tbl_valid[r.sid]) begin
          tbl_valid[r.sid] = 1'b0;
          live_cnt--;
        end
      end
      rstab_pkg::REQ_QUERY: begin
        o.slot = r.sid;
        if (usable) begin
          o.prog = tbl_prog[r.sid];
          o.reached = (tbl_prog[r.sid] == rstab_pkg::FULL_SCALE);
          o.fin = tbl_back[r.sid] && (tbl_prog[r.sid] == 0);
          o.os = tbl_start[r.sid];
          o.oe = tbl_end[r.sid];
        end
      end
      default: ;
    endcase
    pending_reqs.push_back(r);
    pending_rsps.push_back(o);
  endfunction

  function automatic ramp_req_t mk(input logic [2:0] req, input int sid,
                                   input logic [31:0] dur, input logic [31:0] sv,
                                   input logic [31:0] ev, input logic [31:0] el);
    ramp_req_t r;
    r.req = req;
    r.sid = sid[8:0];
    r.dur = dur;
    r.sv = sv;
    r.ev = ev;
    r.el = el;
    return r;
  endfunction

  function automatic logic [31:0] rand_dur();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  function automatic logic [31:0] rand_el();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  // a slot that has been created at some point, or slot 0
  function automatic int made_slot();
    int s;
    for (int k = 0; k < 20; k++) begin
      s = $urandom_range(1, SLOTS - 1);
      if (tbl_made[s]) return s;
    end
    return 0;
  endfunction

  // a slot that is currently live, else anything
  function automatic int live_slot();
    int s;
    for (int k = 0; k < 20; k++) begin
      s = $urandom_range(1, SLOTS - 1);
      if (tbl_valid[s]) return s;
    end
    return $urandom_range(0, SLOTS - 1);
  endfunction

  // one random request; rel_bias raises the share of releases
  function automatic void rand_issue(input int rel_bias);
    int w;
    int sid;
    w = $urandom_range(0, 99);
    sid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOTS - 1) : live_slot();
    if (w < 20 && live_cnt < 40)
      issue(mk(rstab_pkg::REQ_CREATE, $urandom_range(0, 511), rand_dur(), $urandom(),
               $urandom, 0));
    else if (w < 30)
      issue(mk(rstab_pkg::REQ_TICK, $urandom_range(0, 511), 0, 0, 0, rand_el()));
    else if (w < 42)
      issue(mk(rstab_pkg::REQ_FORWARD, sid, $urandom(), 0, 0, $urandom()));
    else if (w < 54)
      issue(mk(rstab_pkg::REQ_BACKWARD, sid, 0, $urandom(), 0, 0));
    else if (w < 64 + rel_bias)
      issue(mk(rstab_pkg::REQ_RELEASE, sid, 0, 0, $urandom(), 0));
    else if (w < 97)
      issue(mk(rstab_pkg::REQ_QUERY, made_slot(), $urandom(), $urandom(), $urandom(),
               $urandom()));
    else
      issue(mk($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
               $urandom_range(0, 511), $urandom(), $urandom(), $urandom(), $urandom()));
  endfunction

  // stimulus
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_made[i] = 1'b0;
      tbl_dur[i] = '0;
      tbl_start[i] = '0;
      tbl_end[i] = '0;
      tbl_prog[i] = '0;
      tbl_back[i] = 1'b0;
    end
    tbl_next = 0;
    live_cnt = 0;

    // directed: field extremes, every request, corner slots
    issue(mk(rstab_pkg::REQ_CREATE, 0, 32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    issue(mk(rstab_pkg::REQ_CREATE, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    issue(mk(rstab_pkg::REQ_CREATE, 0, 32'd0, 32'hFFFF_FFFF, 32'd0, 0));
    issue(mk(rstab_pkg::REQ_CREATE, 0, 32'd1, 32'd0, 32'hFFFF_FFFF, 0));
    issue(mk(rstab_pkg::REQ_TICK, 0, 0, 0, 0, 32'd0));
    issue(mk(rstab_pkg::REQ_TICK, 0, 0, 0, 0, 32'd250));
    issue(mk(rstab_pkg::REQ_QUERY, 1, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_BACKWARD, 1, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_TICK, 0, 0, 0, 0, 32'd300));
    issue(mk(rstab_pkg::REQ_QUERY, 1, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_FORWARD, 1, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
    issue(mk(rstab_pkg::REQ_QUERY, 1, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_QUERY, 2, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_QUERY, 3, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_QUERY, 4, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_FORWARD, 0, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_BACKWARD, 511, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_RELEASE, 0, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_RELEASE, 2, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_QUERY, 2, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_QUERY, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF));
    issue(mk(REQ_SPARE_A, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    issue(mk(REQ_SPARE_B, 5, 1, 1, 1, 1));

    // mixed traffic on a sparse table
    repeat (330) rand_issue(0);
    // fill the table to the brim, then hit the full case
    repeat (SLOTS + 4) issue(mk(rstab_pkg::REQ_CREATE, $urandom_range(0, 511), rand_dur(),
                                $urandom(), $urandom(), $urandom()));
    issue(mk(rstab_pkg::REQ_TICK, 0, 0, 0, 0, 32'd700));
    issue(mk(rstab_pkg::REQ_QUERY, 511, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_RELEASE, 300, 0, 0, 0, 0));
    issue(mk(rstab_pkg::REQ_CREATE, 0, 32'd5, 32'd7, 32'd9, 0));
    issue(mk(rstab_pkg::REQ_CREATE, 0, 32'd5, 32'd7, 32'd9, 0));
    issue(mk(rstab_pkg::REQ_QUERY, 300, 0, 0, 0, 0));
    // drain the table back down with release-heavy traffic
    repeat (300) rand_issue(33);
    gen_done = 1'b1;
  end

  // reset, then wait for everything to drain
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (gen_done);
    while (pending_reqs.size() != 0 || awaited_rsps.size() != 0 || in_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errs == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // acceptance: log the expected result of each input beat
  always @(posedge clk) begin
    cyc <= cyc + 1;
    took = in_valid && !in_stall && rst_n;
    if (took) awaited_rsps.push_back(pending_rsps.pop_front());
  end

  // driver: random gaps outside a quiet window
  always @(negedge clk) begin
    ramp_req_t r;
    bit gap;
    gap = (cyc < 40000 || cyc > 90000) && ($urandom_range(0, 99) < 20);
    if (!in_valid || took) begin
      if (rst_n && gen_done !== 1'bx && pending_reqs.size() != 0 && !gap) begin
        r = pending_reqs.pop_front();
        in_req_type <= r.req;
        in_slot_id <= r.sid;
        in_duration_us <= r.dur;
        in_start_value <= r.sv;
        in_end_value <= r.ev;
        in_elapsed_us <= r.el;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= (cyc < 50000 || cyc > 100000) && ($urandom_range(0, 99) < 20);
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    ramp_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_rsps.size() == 0) begin
        $display("%0t: unexpected result beat slot=%0d", $time, out_result_slot);
        errs++;
      end else begin
        e = awaited_rsps.pop_front();
        if (out_result_slot !== e.slot) begin
          $display("%0t: result_slot exp %0d got %0d", $time, e.slot, out_result_slot);
          errs++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          errs++;
        end
        if (out_progress !== e.prog) begin
          $display("%0t: progress exp %0d got %0d", $time, e.prog, out_progress);
          errs++;
        end
        if (out_reached_end !== e.reached) begin
          $display("%0t: reached_end exp %0d got %0d", $time, e.reached, out_reached_end);
          errs++;
        end
        if (out_finished !== e.fin) begin
          $display("%0t: finished exp %0d got %0d", $time, e.fin, out_finished);
          errs++;
        end
        if (out_start !== e.os) begin
          $display("%0t: start exp %h got %h", $time, e.os, out_start);
          errs++;
        end
        if (out_end !== e.oe) begin
          $display("%0t: end exp %h got %h", $time, e.oe, out_end);
          errs++;
        end
      end
    end
  end

endmodule
`default_nettype wire
